/* rtl/lhp_pkg.sv */
package lhp_pkg;

    // Field and register widths
    localparam int TICKS_W   = 48;
    localparam int US_W      = 32;
    localparam int CNT_W     = 32;
    localparam int SUM_W     = 48;
    localparam int Q_W       = 17;
    localparam int Q_FRAC    = 16;
    localparam int TPS_W     = 32;
    localparam int BW_W      = 16;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 1;

    // Tick to microsecond conversion
    localparam int                USPS_W    = 20;
    localparam logic [USPS_W-1:0] US_PER_S  = 20'd1000000;
    localparam int                PROD_W    = TICKS_W + USPS_W;
    localparam int                DIV_CNT_W = $clog2(PROD_W);

    // Percentile threshold product
    localparam int QPROD_W = CNT_W + Q_W;
    localparam int THR_W   = QPROD_W - Q_FRAC;

    // Register reset values
    localparam logic [TPS_W-1:0] TPS_RESET = 32'd10000000;
    localparam logic [BW_W-1:0]  BW_RESET  = 16'd100;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TICKS_PER_SECOND = 1'b0,
        CFG_BUCKET_WIDTH_US  = 1'b1
    } cfg_index_t;

    typedef enum logic {
        MODE_RECORD = 1'b0,
        MODE_QUERY  = 1'b1
    } mode_t;

endpackage

/* rtl/lhp_ram.sv */
module lhp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/latency_histogram_percentile.sv */
// Latency statistics unit. A beat with s_mode = record converts s_elapsed_ticks to
// microseconds (ticks * 1000000 / ticks_per_second, saturated to 32 bits), bumps the
// sample count, adds to the saturating sum, updates the maximum and increments the
// histogram bin us / bucket_width_us (last bin catches everything above). A beat with
// s_mode = query returns bin_index * bucket_width_us of the first bin whose running
// count reaches floor(count * quantile / 65536), the maximum if none does, and 0 with
// no samples; queries change no state. Every input beat yields one result beat that
// also carries the statistics after the step. One item is in flight at a time. A
// record passes through the bit-serial divider that converts ticks, then the bin
// index divider (skipped when the value falls in the last bin), and then the
// read-modify-write of the bin counter in the histogram RAM. A query walks the
// bins from bin 0, one RAM read per cycle, until the running count reaches the
// threshold or the last bin is summed; a query with no samples skips the walk.
// After reset the block sweeps the histogram RAM to zero, one bin per cycle, with
// s_ready low; configuration writes are taken during the sweep.
// Write configuration only while the block is idle.
module latency_histogram_percentile #(
    parameter int NUM_BINS = 64
) (
    input  logic                           aclk,
    input  logic                           aresetn,

    input  logic                           cfg_wr_en,
    input  logic [lhp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lhp_pkg::CFG_W-1:0]      cfg_wdata,

    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_mode,
    input  logic [lhp_pkg::TICKS_W-1:0]    s_elapsed_ticks,
    input  logic [lhp_pkg::Q_W-1:0]        s_quantile,

    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [lhp_pkg::US_W-1:0]       m_result_us,
    output logic [lhp_pkg::CNT_W-1:0]      m_sample_count,
    output logic [lhp_pkg::SUM_W-1:0]      m_sum_us,
    output logic [lhp_pkg::US_W-1:0]       m_max_us
);

    localparam int US_W    = lhp_pkg::US_W;
    localparam int CNT_W   = lhp_pkg::CNT_W;
    localparam int SUM_W   = lhp_pkg::SUM_W;
    localparam int BW_W    = lhp_pkg::BW_W;
    localparam int TPS_W   = lhp_pkg::TPS_W;
    localparam int PROD_W  = lhp_pkg::PROD_W;
    localparam int QPROD_W = lhp_pkg::QPROD_W;
    localparam int THR_W   = lhp_pkg::THR_W;
    localparam int DCNT_W  = lhp_pkg::DIV_CNT_W;

    // Bin index, bin limit and walk accumulator widths
    localparam int BIN_W = $clog2(NUM_BINS);
    localparam int LIM_W = BW_W + BIN_W;
    localparam int RUN_W = CNT_W + BIN_W;
    localparam int K_W   = $clog2(BIN_W + 1);

    localparam logic [BIN_W-1:0]  LAST_BIN = BIN_W'(NUM_BINS - 1);
    localparam logic [DCNT_W-1:0] DIV_LAST = DCNT_W'(PROD_W - 1);

    typedef enum logic [3:0] {
        ST_CLR,
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_BCHK,
        ST_BDIV,
        ST_RD,
        ST_RMW,
        ST_QMUL,
        ST_QWALK,
        ST_OUT
    } state_t;

    state_t state_reg;

    // Configuration
    logic [TPS_W-1:0] tps_reg;
    logic [BW_W-1:0]  bw_reg;
    logic [TPS_W-1:0] tps_eff;
    logic [BW_W-1:0]  bw_eff;

    // Captured input beat
    logic [lhp_pkg::TICKS_W-1:0] ticks_reg;
    logic [lhp_pkg::Q_W-1:0]     quantile_reg;

    // Tick conversion divider
    logic [PROD_W-1:0]  prod_reg;
    logic [TPS_W-1:0]   rem_reg;
    logic [US_W-1:0]    quo_reg;
    logic               ovf_reg;
    logic [DCNT_W-1:0]  div_cnt_reg;
    logic [PROD_W-1:0]  tprod;
    logic [TPS_W:0]     rem_sh;
    logic [TPS_W:0]     rem_sub;
    logic               div_ge;
    logic [TPS_W-1:0]   rem_new;
    logic [US_W-1:0]    us_w;

    // Bin index divider
    logic [LIM_W-1:0]   lim_reg;
    logic [LIM_W-1:0]   rem2_reg;
    logic [K_W-1:0]     k_reg;
    logic [BIN_W-1:0]   bin_reg;
    logic [LIM_W-1:0]   bdiv_dv;
    logic               bdiv_ge;

    // Running statistics
    logic [CNT_W-1:0]   samples_reg;
    logic [SUM_W-1:0]   total_us_reg;
    logic [US_W-1:0]    largest_reg;
    logic [SUM_W:0]     sum_add;
    logic [SUM_W-1:0]   sum_sat;

    // Percentile walk
    logic [QPROD_W-1:0] qprod;
    logic [THR_W-1:0]   thr_reg;
    logic [RUN_W-1:0]   run_reg;
    logic [RUN_W-1:0]   run_sum;
    logic               run_hit;
    logic [LIM_W-1:0]   base_reg;
    logic [BIN_W-1:0]   walk_idx_reg;

    logic [BIN_W-1:0]   clr_idx_reg;
    logic [US_W-1:0]    result_reg;

    // Output register
    logic               m_valid_reg;
    logic [US_W-1:0]    m_result_reg;
    logic [CNT_W-1:0]   m_count_reg;
    logic [SUM_W-1:0]   m_sum_reg;
    logic [US_W-1:0]    m_max_reg;

    // Histogram RAM port
    logic               ram_we;
    logic [BIN_W-1:0]   ram_waddr;
    logic [CNT_W-1:0]   ram_wdata;
    logic [BIN_W-1:0]   ram_raddr;
    logic [CNT_W-1:0]   ram_rdata;
    logic [CNT_W-1:0]   bin_inc;

    // A zero frequency or zero bin width acts as one
    assign tps_eff = (tps_reg == '0) ? TPS_W'(1) : tps_reg;
    assign bw_eff  = (bw_reg == '0) ? BW_W'(1) : bw_reg;

    // Restoring division step: one quotient bit per cycle, MSB of the product first
    assign tprod   = PROD_W'(ticks_reg) * PROD_W'(lhp_pkg::US_PER_S);
    assign rem_sh  = {rem_reg, prod_reg[PROD_W-1]};
    assign div_ge  = rem_sh >= {1'b0, tps_eff};
    assign rem_sub = rem_sh - {1'b0, tps_eff};
    assign rem_new = div_ge ? rem_sub[TPS_W-1:0] : rem_sh[TPS_W-1:0];
    // Any quotient bit pushed out above bit 31 means the value saturates
    assign us_w    = ovf_reg ? '1 : quo_reg;

    assign sum_add = {1'b0, total_us_reg} + (SUM_W + 1)'(us_w);
    assign sum_sat = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];

    // Bin index: compare against bucket_width shifted by the current quotient bit
    assign bdiv_dv = LIM_W'(bw_eff) << k_reg;
    assign bdiv_ge = rem2_reg >= bdiv_dv;

    assign bin_inc = (ram_rdata == '1) ? ram_rdata : ram_rdata + CNT_W'(1);

    assign qprod   = QPROD_W'(samples_reg) * QPROD_W'(quantile_reg);
    assign run_sum = run_reg + RUN_W'(ram_rdata);
    assign run_hit = run_sum >= RUN_W'(thr_reg);

    // RAM address and write select
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = bin_reg;
        ram_wdata = bin_inc;
        ram_raddr = bin_reg;
        unique case (state_reg)
            ST_CLR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_idx_reg;
                ram_wdata = '0;
            end
            ST_RMW: begin
                ram_we    = 1'b1;
            end
            ST_QMUL: begin
                ram_raddr = '0;
            end
            ST_QWALK: begin
                // prefetch the next bin while the current one is summed
                ram_raddr = walk_idx_reg + BIN_W'(1);
            end
            default: begin
            end
        endcase
    end

    lhp_ram #(
        .WIDTH (CNT_W),
        .DEPTH (NUM_BINS)
    ) u_bins (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLR;
            clr_idx_reg  <= '0;
            m_valid_reg  <= 1'b0;
            tps_reg      <= lhp_pkg::TPS_RESET;
            bw_reg       <= lhp_pkg::BW_RESET;
            samples_reg  <= '0;
            total_us_reg <= '0;
            largest_reg  <= '0;
        end else begin
            // Last-bin limit follows the bin width; settles long before it is used
            lim_reg <= LIM_W'(bw_eff) * LIM_W'(LAST_BIN);

            if (cfg_wr_en) begin
                unique case (lhp_pkg::cfg_index_t'(cfg_index))
                    lhp_pkg::CFG_TICKS_PER_SECOND: tps_reg <= cfg_wdata[TPS_W-1:0];
                    lhp_pkg::CFG_BUCKET_WIDTH_US:  bw_reg  <= cfg_wdata[BW_W-1:0];
                    default: begin
                    end
                endcase
            end

            // Drop the result beat once taken; in ST_OUT a new beat takes its place
            if (m_valid_reg && m_ready && state_reg != ST_OUT) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_CLR: begin
                    clr_idx_reg <= clr_idx_reg + BIN_W'(1);
                    if (clr_idx_reg == LAST_BIN) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (s_valid) begin
                        ticks_reg    <= s_elapsed_ticks;
                        quantile_reg <= s_quantile;
                        if (lhp_pkg::mode_t'(s_mode) == lhp_pkg::MODE_QUERY) begin
                            if (samples_reg == '0) begin
                                result_reg <= '0;
                                state_reg  <= ST_OUT;
                            end else begin
                                state_reg  <= ST_QMUL;
                            end
                        end else begin
                            state_reg <= ST_MUL;
                        end
                    end
                end
                ST_MUL: begin
                    prod_reg    <= tprod;
                    rem_reg     <= '0;
                    quo_reg     <= '0;
                    ovf_reg     <= 1'b0;
                    div_cnt_reg <= '0;
                    state_reg   <= ST_DIV;
                end
                ST_DIV: begin
                    prod_reg    <= prod_reg << 1;
                    rem_reg     <= rem_new;
                    quo_reg     <= {quo_reg[US_W-2:0], div_ge};
                    ovf_reg     <= ovf_reg | quo_reg[US_W-1];
                    div_cnt_reg <= div_cnt_reg + DCNT_W'(1);
                    if (div_cnt_reg == DIV_LAST) begin
                        state_reg <= ST_BCHK;
                    end
                end
                ST_BCHK: begin
                    result_reg   <= us_w;
                    total_us_reg <= sum_sat;
                    if (samples_reg != '1) begin
                        samples_reg <= samples_reg + CNT_W'(1);
                    end
                    if (us_w > largest_reg) begin
                        largest_reg <= us_w;
                    end
                    if (us_w >= US_W'(lim_reg)) begin
                        bin_reg   <= LAST_BIN;
                        state_reg <= ST_RD;
                    end else begin
                        bin_reg   <= '0;
                        rem2_reg  <= LIM_W'(us_w);
                        k_reg     <= K_W'(BIN_W - 1);
                        state_reg <= ST_BDIV;
                    end
                end
                ST_BDIV: begin
                    if (bdiv_ge) begin
                        rem2_reg <= rem2_reg - bdiv_dv;
                        bin_reg  <= bin_reg | (BIN_W'(1) << k_reg);
                    end
                    if (k_reg == '0) begin
                        state_reg <= ST_RD;
                    end else begin
                        k_reg <= k_reg - K_W'(1);
                    end
                end
                ST_RD: begin
                    state_reg <= ST_RMW;
                end
                ST_RMW: begin
                    state_reg <= ST_OUT;
                end
                ST_QMUL: begin
                    thr_reg      <= qprod[QPROD_W-1:lhp_pkg::Q_FRAC];
                    run_reg      <= '0;
                    base_reg     <= '0;
                    walk_idx_reg <= '0;
                    state_reg    <= ST_QWALK;
                end
                ST_QWALK: begin
                    if (run_hit) begin
                        result_reg <= US_W'(base_reg);
                        state_reg  <= ST_OUT;
                    end else if (walk_idx_reg == LAST_BIN) begin
                        result_reg <= largest_reg;
                        state_reg  <= ST_OUT;
                    end else begin
                        run_reg      <= run_sum;
                        base_reg     <= base_reg + LIM_W'(bw_eff);
                        walk_idx_reg <= walk_idx_reg + BIN_W'(1);
                    end
                end
                ST_OUT: begin
                    // Hold until the output register is free
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg  <= 1'b1;
                        m_result_reg <= result_reg;
                        m_count_reg  <= samples_reg;
                        m_sum_reg    <= total_us_reg;
                        m_max_reg    <= largest_reg;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_ready        = (state_reg == ST_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_result_us    = m_result_reg;
    assign m_sample_count = m_count_reg;
    assign m_sum_us       = m_sum_reg;
    assign m_max_us       = m_max_reg;

endmodule

/* rtl/lhp_checker.sv */
module lhp_checker (
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      s_valid,
    input logic                      s_ready,
    input logic                      m_valid,
    input logic                      m_ready,
    input logic [lhp_pkg::US_W-1:0]  m_result_us,
    input logic [lhp_pkg::CNT_W-1:0] m_sample_count,
    input logic [lhp_pkg::SUM_W-1:0] m_sum_us,
    input logic [lhp_pkg::US_W-1:0]  m_max_us
);

    localparam int SUM_W = lhp_pkg::SUM_W;

    // One item at a time: an accepted beat is followed by s_ready low
    a_busy_after_accept: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready
    ) else $error("input accepted again right after a beat");

    // A stalled result beat holds its payload
    a_out_hold: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_result_us)
            && $stable(m_sample_count) && $stable(m_sum_us) && $stable(m_max_us))
    ) else $error("result beat dropped or changed while stalled");

    // The saturating sum never falls below the largest single sample
    a_sum_covers_max: assert property (
        @(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_sum_us >= SUM_W'(m_max_us))
    ) else $error("sum below maximum");

    // With no samples recorded every statistic and the query result are zero
    a_empty_zero: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_sample_count == '0)) |->
            (m_result_us == '0 && m_sum_us == '0 && m_max_us == '0)
    ) else $error("nonzero statistics with no samples");

endmodule

bind latency_histogram_percentile lhp_checker u_lhp_checker (.*);
